// File: hdl/ice_alu_pkg.sv
// Package with opcode and error code constants for the constant-expression ALU.
package ice_alu_pkg;
  localparam int DataW = 32;
  localparam int OpW = 5;
  localparam int ErrW = 2;

  localparam logic [OpW-1:0] OP_HIGH = 5'd0;
  localparam logic [OpW-1:0] OP_LOW = 5'd1;
  localparam logic [OpW-1:0] OP_LNOT = 5'd2;
  localparam logic [OpW-1:0] OP_PLUS = 5'd3;
  localparam logic [OpW-1:0] OP_NEG = 5'd4;
  localparam logic [OpW-1:0] OP_NOT = 5'd5;
  localparam logic [OpW-1:0] OP_LOR = 5'd6;
  localparam logic [OpW-1:0] OP_LAND = 5'd7;
  localparam logic [OpW-1:0] OP_EQ = 5'd8;
  localparam logic [OpW-1:0] OP_GT = 5'd9;
  localparam logic [OpW-1:0] OP_LT = 5'd10;
  localparam logic [OpW-1:0] OP_GE = 5'd11;
  localparam logic [OpW-1:0] OP_LE = 5'd12;
  localparam logic [OpW-1:0] OP_NE = 5'd13;
  localparam logic [OpW-1:0] OP_ADD = 5'd14;
  localparam logic [OpW-1:0] OP_SUB = 5'd15;
  localparam logic [OpW-1:0] OP_XOR = 5'd16;
  localparam logic [OpW-1:0] OP_OR = 5'd17;
  localparam logic [OpW-1:0] OP_AND = 5'd18;
  localparam logic [OpW-1:0] OP_SHL = 5'd19;
  localparam logic [OpW-1:0] OP_SHR = 5'd20;
  localparam logic [OpW-1:0] OP_MUL = 5'd21;
  localparam logic [OpW-1:0] OP_DIV = 5'd22;
  localparam logic [OpW-1:0] OP_MOD = 5'd23;

  localparam logic [ErrW-1:0] ERR_NONE = 2'd0;
  localparam logic [ErrW-1:0] ERR_DIV0 = 2'd1;
  localparam logic [ErrW-1:0] ERR_SHIFT = 2'd2;
  localparam logic [ErrW-1:0] ERR_OP = 2'd3;

  localparam logic [DataW-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [DataW-1:0] BYTE_MASK = 32'h0000_00FF;

  // Divider bits resolved per pipeline stage (32 / 4 = 8 stages).
  localparam int DivBitsPerStage = 4;
  localparam int DivStages = DataW / DivBitsPerStage;

  // Side information carried alongside each item through the pipeline.
  typedef struct packed {
    logic [DataW-1:0] result;
    logic [ErrW-1:0] err;
    logic warn;
    logic is_div;
    logic is_mod;
    logic neg_q;
    logic neg_r;
  } side_t;
endpackage

// File: hdl/ice_alu_div.sv
// Pipelined unsigned restoring divider, a few quotient bits per stage.
module ice_alu_div
  import ice_alu_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic [DataW-1:0] quotient,
  output logic [DataW-1:0] remainder
);
  logic [DataW-1:0] rem [DivStages+1];
  logic [DataW-1:0] quo [DivStages+1];
  logic [DataW-1:0] dvs [DivStages+1];

  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [DataW-1:0] r_c [DivBitsPerStage+1];
    logic [DataW-1:0] q_c [DivBitsPerStage+1];
    logic [DataW-1:0] rem_q, quo_q, dvs_q;
    assign r_c[0] = rem[s];
    assign q_c[0] = quo[s];
    for (genvar k = 0; k < DivBitsPerStage; k++) begin : g_bit
      logic [DataW:0] trial;
      logic [DataW:0] diff;
      assign trial = {r_c[k], q_c[k][DataW-1]};
      assign diff = trial - {1'b0, dvs[s]};
      assign r_c[k+1] = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      assign q_c[k+1] = {q_c[k][DataW-2:0], ~diff[DataW]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= r_c[DivBitsPerStage];
        quo_q <= q_c[DivBitsPerStage];
        dvs_q <= dvs[s];
      end
    end
    assign rem[s+1] = rem_q;
    assign quo[s+1] = quo_q;
    assign dvs[s+1] = dvs_q;
  end

  assign quotient = quo[DivStages];
  assign remainder = rem[DivStages];
endmodule

// File: hdl/int32_constant_expression_alu.sv
// Top level of the pipelined signed 32-bit constant-expression ALU.
//
// One input channel (valid/ready) carries op, operand_a and operand_b; one
// output channel (valid/ready) returns result, error_code and warn. Every
// input beat gives exactly one output beat, in order.
// The pipeline has a fixed depth of DivStages + 2 register stages (10 with
// the default four divider bits per stage): one operand stage, the divider
// stages, and one result stage. All operations pass through the same
// stages, so a new beat may enter every cycle and throughput is one beat
// per cycle while the output is not stalled.
// The divider, resolving four quotient bits per stage, sets the depth.
// The multiply is formed in the first stage and carried along.
// If out_ready is low while the last stage holds a beat, the whole pipeline
// freezes: valid bits and data stay in place, and in_ready is low only while
// the last stage holds a beat that is not taken. Bubbles inside the pipeline
// are not squeezed out, since all stages share one enable and move together.
// Reset clears all valid bits; data registers are not reset.
module int32_constant_expression_alu
  import ice_alu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OpW-1:0]   op,
  input  logic signed [DataW-1:0] operand_a,
  input  logic signed [DataW-1:0] operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [DataW-1:0] result,
  output logic [ErrW-1:0]  error_code,
  output logic             warn
);
  localparam int Depth = DivStages + 2;

  // A single global enable keeps the divider stages in lockstep with side data.
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  logic [Depth-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end
  assign out_valid = vld[Depth-1];

  // First stage: everything except division.
  logic [DataW-1:0] a, b, mag_a, mag_b, r0;
  logic [ErrW-1:0] e0;
  logic w0, neg_a, neg_b, sa_lt, is_div, is_mod, special;
  assign a = operand_a;
  assign b = operand_b;
  assign neg_a = a[DataW-1];
  assign neg_b = b[DataW-1];
  assign mag_a = neg_a ? (DataW'(0) - a) : a;
  assign mag_b = neg_b ? (DataW'(0) - b) : b;
  assign sa_lt = operand_a < operand_b;
  assign special = (a == INT_MIN) && (b == '1);

  always_comb begin
    r0 = '0;
    e0 = ERR_NONE;
    w0 = 1'b0;
    is_div = 1'b0;
    is_mod = 1'b0;
    case (op)
      OP_HIGH: r0 = (a >> 8) & BYTE_MASK;
      OP_LOW:  r0 = a & BYTE_MASK;
      OP_LNOT: r0 = DataW'(a == '0);
      OP_PLUS: r0 = a;
      OP_NEG:  r0 = DataW'(0) - a;
      OP_NOT:  r0 = ~a;
      OP_LOR:  r0 = DataW'((a != '0) || (b != '0));
      OP_LAND: r0 = DataW'((a != '0) && (b != '0));
      OP_EQ:   r0 = DataW'(a == b);
      OP_GT:   r0 = DataW'(!sa_lt && (a != b));
      OP_LT:   r0 = DataW'(sa_lt);
      OP_GE:   r0 = DataW'(!sa_lt);
      OP_LE:   r0 = DataW'(sa_lt || (a == b));
      OP_NE:   r0 = DataW'(a != b);
      OP_ADD:  r0 = a + b;
      OP_SUB:  r0 = a - b;
      OP_XOR:  r0 = a ^ b;
      OP_OR:   r0 = a | b;
      OP_AND:  r0 = a & b;
      OP_SHL: begin
        w0 = neg_a;
        if (b > 32'd31) e0 = ERR_SHIFT;
        else r0 = a << b[4:0];
      end
      OP_SHR: begin
        if (b > 32'd31) e0 = ERR_SHIFT;
        else r0 = DataW'(operand_a >>> b[4:0]);
      end
      OP_MUL:  r0 = a * b;
      OP_DIV: begin
        if (b == '0) e0 = ERR_DIV0;
        else if (special) begin
          r0 = INT_MIN;
          w0 = 1'b1;
        end else is_div = 1'b1;
      end
      OP_MOD: begin
        if (b == '0) e0 = ERR_DIV0;
        else if (!special) is_mod = 1'b1;
      end
      default: e0 = ERR_OP;
    endcase
  end

  side_t side [Depth-1];
  logic [DataW-1:0] dvd, dvs;
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{result: r0, err: e0, warn: w0, is_div: is_div, is_mod: is_mod,
                   neg_q: neg_a ^ neg_b, neg_r: neg_a};
      dvd <= mag_a;
      dvs <= mag_b;
      for (int i = 1; i < Depth - 1; i++) side[i] <= side[i-1];
    end
  end

  logic [DataW-1:0] q, rm;
  ice_alu_div u_div (
    .clk(clk), .en(adv), .dividend(dvd), .divisor(dvs),
    .quotient(q), .remainder(rm)
  );

  // Final stage: sign fix-up of the divider outputs.
  side_t sl;
  logic [DataW-1:0] res_next;
  assign sl = side[Depth-2];
  always_comb begin
    res_next = sl.result;
    if (sl.is_div) res_next = sl.neg_q ? (DataW'(0) - q) : q;
    else if (sl.is_mod) res_next = sl.neg_r ? (DataW'(0) - rm) : rm;
  end

  logic [DataW-1:0] res_q;
  logic [ErrW-1:0] err_q;
  logic warn_q;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
      err_q <= sl.err;
      warn_q <= sl.warn;
    end
  end
  assign result = res_q;
  assign error_code = err_q;
  assign warn = warn_q;
endmodule
